// ===== rtl/gss_pkg.sv =====
package gss_pkg;

    // Field types shared by the channels and the sequencer.
    typedef logic [3:0] t_gear;
    typedef logic [2:0] t_phase;
    typedef logic [1:0] t_fault;
    typedef logic [4:0] t_set;
    typedef logic [6:0] t_pct;

    // Width of a percentage value.
    localparam int PCT_W = 7;

    // Width of the timing registers.
    localparam int MS_W = 16;

    // Width of the packed clutch table register.
    localparam int TABLE_W = 50;

    // Gear codes.
    localparam t_gear GEAR_NEUTRAL = 4'd0;
    localparam t_gear GEAR_FIRST   = 4'd1;
    localparam t_gear GEAR_TOP     = 4'd8;
    localparam t_gear GEAR_REVERSE = 4'd9;

    // Phase codes as reported on the result channel.
    localparam t_phase PH_IDLE    = 3'd0;
    localparam t_phase PH_PREFILL = 3'd1;
    localparam t_phase PH_CUT     = 3'd2;
    localparam t_phase PH_OVERLAP = 3'd3;
    localparam t_phase PH_DONE    = 3'd4;

    // Fault codes.
    localparam t_fault FLT_NONE    = 2'd0;
    localparam t_fault FLT_INVALID = 2'd1;
    localparam t_fault FLT_TIMEOUT = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_PREFILL_TIME = 3'd0;
    localparam logic [2:0] CFG_ACK_TIMEOUT  = 3'd1;
    localparam logic [2:0] CFG_OVERLAP_TIME = 3'd2;
    localparam logic [2:0] CFG_RESTORE_TIME = 3'd3;
    localparam logic [2:0] CFG_PREFILL_PCT  = 3'd4;
    localparam logic [2:0] CFG_CLUTCH_TABLE = 3'd5;

    // Full scale of the ramp progress.
    localparam t_pct PROG_MAX = 7'd100;

endpackage

// ===== rtl/gss_tick_if.sv =====
interface gss_tick_if;
    logic            valid;
    logic            ready;
    logic [31:0]     now_ms;
    logic            request_valid;
    gss_pkg::t_gear  requested_gear;
    logic            torque_ack;

    modport source (
        output valid, now_ms, request_valid, requested_gear, torque_ack,
        input  ready
    );
    modport sink (
        input  valid, now_ms, request_valid, requested_gear, torque_ack,
        output ready
    );
endinterface

// ===== rtl/gss_result_if.sv =====
interface gss_result_if;
    logic            valid;
    logic            ready;
    gss_pkg::t_gear  gear_now;
    gss_pkg::t_gear  gear_goal;
    gss_pkg::t_phase phase_code;
    gss_pkg::t_fault fault_code;
    logic            in_shift;
    gss_pkg::t_set   held_set;
    gss_pkg::t_set   ramp_in_set;
    gss_pkg::t_set   ramp_out_set;
    gss_pkg::t_pct   ramp_pct;
    logic            cut_req;

    modport source (
        output valid, gear_now, gear_goal, phase_code, fault_code, in_shift,
               held_set, ramp_in_set, ramp_out_set, ramp_pct,
               cut_req,
        input  ready
    );
    modport sink (
        input  valid, gear_now, gear_goal, phase_code, fault_code, in_shift,
               held_set, ramp_in_set, ramp_out_set, ramp_pct,
               cut_req,
        output ready
    );
endinterface

// ===== rtl/gss_div.sv =====
// Restoring divider that resolves one quotient bit per cycle.
module gss_div #(
    parameter int NUM_W = 39,
    parameter int DEN_W = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_W - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_quot;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    // One trial subtraction per cycle; the numerator shifts out as quotient bits shift in.
    assign trial = {r_rem, r_quot[NUM_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign fits  = trial >= {1'b0, r_den};

    // Control is reset; the datapath is loaded on start.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_quot <= {r_quot[NUM_W-2:0], fits};
            r_rem  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== rtl/gear_shift_sequencer.sv =====
// Gear shift sequencer. Each tick word carries a millisecond time stamp, an optional new
// target gear and the torque-cut acknowledge; it advances the shift phase machine once and
// produces exactly one result word. The block takes one tick at a time: a tick whose
// result shows prefill with a non-zero prefill time, or overlap with a non-zero overlap
// time, has its result offered once the bit-serial divider has formed the ramp progress
// one quotient bit per cycle; any other tick has its result offered straight after the
// S_PROD step. The next tick can be taken in the cycle after the result word has been
// taken. Configuration writes are taken at any time but are meant to be made while no
// tick is in flight.
module gear_shift_sequencer #(
    parameter int NUM_ELEMENTS = 5,
    parameter int TIME_BITS    = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [2:0]                    i_cfg_idx,
    input  logic [gss_pkg::TABLE_W-1:0]   i_cfg_data,
    gss_tick_if.sink                      i_tick,
    gss_result_if.source                  o_result
);

    localparam int NUM_W   = TIME_BITS + gss_pkg::PCT_W;
    localparam int TBL_X_W = 128;
    localparam logic [7:0] ELEM_MASK = 8'((1 << NUM_ELEMENTS) - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROD,
        S_DIV,
        S_OUT
    } t_seq_state;

    t_seq_state r_state;

    // Configuration registers.
    logic [gss_pkg::MS_W-1:0]    r_prefill_time;
    logic [gss_pkg::MS_W-1:0]    r_ack_timeout;
    logic [gss_pkg::MS_W-1:0]    r_overlap_time;
    logic [gss_pkg::MS_W-1:0]    r_restore_time;
    gss_pkg::t_pct               r_prefill_pct;
    logic [gss_pkg::TABLE_W-1:0] r_clutch_table;

    // Shift state.
    gss_pkg::t_gear         r_cur;
    gss_pkg::t_gear         r_goal;
    gss_pkg::t_gear         r_step;
    gss_pkg::t_phase        r_phase;
    gss_pkg::t_fault        r_fault;
    logic [TIME_BITS-1:0]   r_start;
    logic                   r_ack;
    logic [TIME_BITS-1:0]   r_now;

    gss_pkg::t_gear         n_cur;
    gss_pkg::t_gear         n_goal;
    gss_pkg::t_gear         n_step;
    gss_pkg::t_phase        n_phase;
    gss_pkg::t_fault        n_fault;
    logic [TIME_BITS-1:0]   n_start;
    logic                   n_ack;

    // Result word registers.
    gss_pkg::t_set          r_res_eng;
    gss_pkg::t_set          r_res_in;
    gss_pkg::t_set          r_res_out;
    gss_pkg::t_pct          r_res_prog;
    logic                   r_res_cut;

    logic [TBL_X_W-1:0]     tbl_ext;
    logic [TIME_BITS-1:0]   now_t;
    logic [TIME_BITS-1:0]   el_tick;
    logic                   tick_acc;

    logic [TIME_BITS-1:0]   el_prog;
    gss_pkg::t_pct          mul_k;
    logic [NUM_W-1:0]       prod;
    logic [gss_pkg::MS_W-1:0] div_den;
    logic                   need_div;
    logic                   div_start;
    logic                   div_done;
    logic [NUM_W-1:0]       div_quot;
    gss_pkg::t_pct          direct_prog;

    gss_pkg::t_set          eng;
    gss_pkg::t_set          nxt;
    gss_pkg::t_set          res_eng;
    gss_pkg::t_set          res_in;
    gss_pkg::t_set          res_out;
    logic                   res_cut;

    assign tbl_ext = TBL_X_W'(r_clutch_table);

    // Clutch element set of a gear code; entries past bit 63 of the table read as empty.
    function automatic gss_pkg::t_set set_of(input gss_pkg::t_gear g);
        logic [7:0] s;
        s = '0;
        for (int k = 0; k <= 9; k++) begin
            if (g == 4'(k) && k * NUM_ELEMENTS < 64) begin
                s = tbl_ext[k*NUM_ELEMENTS +: 8] & ELEM_MASK;
            end
        end
        return s[4:0];
    endfunction

    // Next gear on the way to the goal: one forward step, or via neutral.
    function automatic gss_pkg::t_gear plan_step(input gss_pkg::t_gear c,
                                                 input gss_pkg::t_gear g);
        logic           c_fwd;
        logic           g_fwd;
        gss_pkg::t_gear s;
        c_fwd = (c >= gss_pkg::GEAR_FIRST) && (c <= gss_pkg::GEAR_TOP);
        g_fwd = (g >= gss_pkg::GEAR_FIRST) && (g <= gss_pkg::GEAR_TOP);
        s = gss_pkg::GEAR_NEUTRAL;
        if (c == g) begin
            s = c;
        end else if (c_fwd && g_fwd) begin
            s = (g > c) ? c + 4'd1 : c - 4'd1;
        end else if (c == gss_pkg::GEAR_NEUTRAL) begin
            if (g == gss_pkg::GEAR_REVERSE) begin
                s = gss_pkg::GEAR_REVERSE;
            end else if (g_fwd) begin
                s = gss_pkg::GEAR_FIRST;
            end
        end
        return s;
    endfunction

    function automatic gss_pkg::t_pct sat_pct(input logic [NUM_W-1:0] v);
        return (v > NUM_W'(gss_pkg::PROG_MAX)) ? gss_pkg::PROG_MAX : v[6:0];
    endfunction

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefill_time <= '0;
            r_ack_timeout  <= '0;
            r_overlap_time <= '0;
            r_restore_time <= '0;
            r_prefill_pct  <= '0;
            r_clutch_table <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                gss_pkg::CFG_PREFILL_TIME: r_prefill_time <= i_cfg_data[gss_pkg::MS_W-1:0];
                gss_pkg::CFG_ACK_TIMEOUT:  r_ack_timeout  <= i_cfg_data[gss_pkg::MS_W-1:0];
                gss_pkg::CFG_OVERLAP_TIME: r_overlap_time <= i_cfg_data[gss_pkg::MS_W-1:0];
                gss_pkg::CFG_RESTORE_TIME: r_restore_time <= i_cfg_data[gss_pkg::MS_W-1:0];
                gss_pkg::CFG_PREFILL_PCT:  r_prefill_pct  <= i_cfg_data[gss_pkg::PCT_W-1:0];
                gss_pkg::CFG_CLUTCH_TABLE: r_clutch_table <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign tick_acc = i_tick.valid && i_tick.ready;
    assign now_t    = i_tick.now_ms[TIME_BITS-1:0];
    assign el_tick  = now_t - r_start;

    // Phase machine step for the tick on the channel.
    always_comb begin
        n_cur   = r_cur;
        n_goal  = i_tick.request_valid ? i_tick.requested_gear : r_goal;
        n_step  = r_step;
        n_phase = r_phase;
        n_fault = r_fault;
        n_start = r_start;
        n_ack   = r_ack | i_tick.torque_ack;

        // An invalid goal aborts whatever is running.
        if (n_goal > gss_pkg::GEAR_REVERSE) begin
            n_fault = gss_pkg::FLT_INVALID;
            n_goal  = r_cur;
            n_phase = gss_pkg::PH_IDLE;
            n_start = now_t;
            n_ack   = 1'b0;
        end

        unique case (n_phase)
            gss_pkg::PH_IDLE: begin
                if (r_cur != n_goal && n_fault == gss_pkg::FLT_NONE) begin
                    n_step  = plan_step(r_cur, n_goal);
                    n_start = now_t;
                    if (r_cur == gss_pkg::GEAR_NEUTRAL || n_step == gss_pkg::GEAR_NEUTRAL) begin
                        n_phase = gss_pkg::PH_OVERLAP;
                    end else begin
                        n_phase = gss_pkg::PH_PREFILL;
                    end
                end
            end
            gss_pkg::PH_PREFILL: begin
                if (el_tick >= TIME_BITS'(r_prefill_time)) begin
                    n_phase = gss_pkg::PH_CUT;
                    n_start = now_t;
                end
            end
            gss_pkg::PH_CUT: begin
                if (n_ack) begin
                    n_phase = gss_pkg::PH_OVERLAP;
                    n_start = now_t;
                end else if (el_tick >= TIME_BITS'(r_ack_timeout)) begin
                    n_fault = gss_pkg::FLT_TIMEOUT;
                    n_goal  = r_cur;
                    n_phase = gss_pkg::PH_IDLE;
                    n_start = now_t;
                    n_ack   = 1'b0;
                end
            end
            gss_pkg::PH_OVERLAP: begin
                if (el_tick >= TIME_BITS'(r_overlap_time)) begin
                    n_cur   = r_step;
                    n_phase = gss_pkg::PH_DONE;
                    n_start = now_t;
                end
            end
            gss_pkg::PH_DONE: begin
                if (el_tick >= TIME_BITS'(r_restore_time)) begin
                    n_phase = gss_pkg::PH_IDLE;
                    n_start = now_t;
                    n_ack   = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // Progress operands from the updated state: elapsed time scaled by the end percentage.
    assign el_prog  = r_now - r_start;
    assign mul_k    = (r_phase == gss_pkg::PH_PREFILL) ? r_prefill_pct : gss_pkg::PROG_MAX;
    assign prod     = NUM_W'(el_prog) * NUM_W'(mul_k);
    assign div_den  = (r_phase == gss_pkg::PH_PREFILL) ? r_prefill_time : r_overlap_time;
    assign need_div = (r_phase == gss_pkg::PH_PREFILL && r_prefill_time != '0) ||
                      (r_phase == gss_pkg::PH_OVERLAP && r_overlap_time != '0);
    assign div_start = (r_state == S_PROD) && need_div;

    // Progress that needs no division.
    always_comb begin
        unique case (r_phase)
            gss_pkg::PH_PREFILL: direct_prog = '0;
            gss_pkg::PH_CUT:     direct_prog = sat_pct(NUM_W'(r_prefill_pct));
            default:             direct_prog = gss_pkg::PROG_MAX;
        endcase
    end

    // Clutch sets and torque-cut request for the updated state.
    always_comb begin
        eng     = set_of(r_cur);
        nxt     = set_of(r_step);
        res_eng = eng;
        res_in  = '0;
        res_out = '0;
        res_cut = 1'b0;
        unique case (r_phase)
            gss_pkg::PH_PREFILL: begin
                res_in = nxt & ~eng;
            end
            gss_pkg::PH_CUT: begin
                res_in  = nxt & ~eng;
                res_cut = 1'b1;
            end
            gss_pkg::PH_OVERLAP: begin
                res_eng = eng & nxt;
                res_in  = nxt & ~eng;
                res_out = eng & ~nxt;
                res_cut = (r_cur != gss_pkg::GEAR_NEUTRAL) && (r_step != gss_pkg::GEAR_NEUTRAL);
            end
            default: ;
        endcase
    end

    gss_div #(
        .NUM_W (NUM_W),
        .DEN_W (gss_pkg::MS_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (prod),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Sequencer, shift state and result word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cur   <= gss_pkg::GEAR_NEUTRAL;
            r_goal  <= gss_pkg::GEAR_NEUTRAL;
            r_step  <= gss_pkg::GEAR_NEUTRAL;
            r_phase <= gss_pkg::PH_IDLE;
            r_fault <= gss_pkg::FLT_NONE;
            r_start <= '0;
            r_ack   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (tick_acc) begin
                        r_cur   <= n_cur;
                        r_goal  <= n_goal;
                        r_step  <= n_step;
                        r_phase <= n_phase;
                        r_fault <= n_fault;
                        r_start <= n_start;
                        r_ack   <= n_ack;
                        r_now   <= now_t;
                        r_state <= S_PROD;
                    end
                end
                S_PROD: begin
                    r_res_eng <= res_eng;
                    r_res_in  <= res_in;
                    r_res_out <= res_out;
                    r_res_cut <= res_cut;
                    if (need_div) begin
                        r_state <= S_DIV;
                    end else begin
                        r_res_prog <= direct_prog;
                        r_state    <= S_OUT;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_res_prog <= sat_pct(div_quot);
                        r_state    <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (o_result.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_tick.ready = (r_state == S_IDLE);

    assign o_result.valid        = (r_state == S_OUT);
    assign o_result.gear_now     = r_cur;
    assign o_result.gear_goal    = r_goal;
    assign o_result.phase_code   = r_phase;
    assign o_result.fault_code   = r_fault;
    assign o_result.in_shift     = (r_phase != gss_pkg::PH_IDLE);
    assign o_result.held_set     = r_res_eng;
    assign o_result.ramp_in_set  = r_res_in;
    assign o_result.ramp_out_set = r_res_out;
    assign o_result.ramp_pct     = r_res_prog;
    assign o_result.cut_req      = r_res_cut;

    // A fault, once raised, is only cleared by reset.
    a_fault_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fault != gss_pkg::FLT_NONE) |=> (r_fault != gss_pkg::FLT_NONE))
        else $error("fault code cleared without reset");

    // No new tick is taken while a result word is on offer.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> !i_tick.ready)
        else $error("tick accepted while result pending");

    // The divider only finishes while the sequencer waits for it.
    a_div_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide step");

    // Progress stays within full scale.
    a_prog_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.ramp_pct <= gss_pkg::PROG_MAX))
        else $error("ramp progress above full scale");

    // Idle never asks for a torque cut or fills a clutch.
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.phase_code == gss_pkg::PH_IDLE) |->
            (!o_result.cut_req && o_result.ramp_in_set == '0 &&
             o_result.ramp_out_set == '0))
        else $error("idle result with active clutch ramp or torque cut");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int ELEMENTS       = 5;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_TICKS    = 310;

    // One tick word and one result word, laid out in port order.
    typedef struct packed {
        logic [31:0]    now_ms;
        logic           request;
        gss_pkg::t_gear gear;
        logic           ack;
    } t_tick;

    typedef struct packed {
        gss_pkg::t_gear  gear_now;
        gss_pkg::t_gear  gear_goal;
        gss_pkg::t_phase phase;
        gss_pkg::t_fault fault;
        logic            active;
        gss_pkg::t_set   engaged;
        gss_pkg::t_set   ramp_in;
        gss_pkg::t_set   ramp_out;
        gss_pkg::t_pct   progress;
        logic            cut_request;
    } t_shift_result;

    // How the random tick generator shapes its words.
    typedef enum {GEN_SAFE, GEN_STARVE, GEN_FREE} t_gen_mode;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n;
    logic                         cfg_we;
    logic [2:0]                   cfg_idx;
    logic [gss_pkg::TABLE_W-1:0]  cfg_data;

    gss_tick_if   tick_bus ();
    gss_result_if result_bus ();

    gear_shift_sequencer #(
        .NUM_ELEMENTS(ELEMENTS),
        .TIME_BITS   (32)
    ) i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_tick    (tick_bus),
        .o_result  (result_bus)
    );

    // Clock with a 10 ns period.
    always #5 i_clk = ~i_clk;

    // Shadow copy of the sequencer state.
    gss_pkg::t_gear  m_cur;
    gss_pkg::t_gear  m_goal;
    gss_pkg::t_gear  m_step;
    gss_pkg::t_phase m_phase;
    gss_pkg::t_fault m_fault;
    logic [31:0]     m_start;
    logic            m_ack;

    // Shadow copy of the configuration registers.
    logic [gss_pkg::MS_W-1:0]    c_prefill;
    logic [gss_pkg::MS_W-1:0]    c_ack_to;
    logic [gss_pkg::MS_W-1:0]    c_overlap;
    logic [gss_pkg::MS_W-1:0]    c_restore;
    gss_pkg::t_pct               c_pct;
    logic [gss_pkg::TABLE_W-1:0] c_table;

    // Stimulus and scoreboard bookkeeping.
    t_tick          pending_ticks[$];
    t_shift_result  expected_results[$];
    t_tick          tick_word;
    t_shift_result  got;
    t_shift_result  want;
    logic [31:0]    clock_ms;
    int unsigned    ticks_issued;
    int unsigned    ticks_taken;
    int unsigned    results_checked;
    int unsigned    mismatch_count;
    int unsigned    gear_changes;
    int unsigned    settings_applied;
    int unsigned    idle_cycles;
    int unsigned    tick_gap;
    int unsigned    ready_gap;
    int unsigned    hold_left;
    int unsigned    gap_draw;
    bit             hold_request;
    bit             calm_mode;
    bit             tick_taken;
    bit             result_taken;

    // Gap length between words: mostly none or short, now and then long.
    function automatic int unsigned draw_gap();
        int unsigned r;
        if (calm_mode) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 88) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Clutch element set of a gear code, taken from the packed table.
    function automatic gss_pkg::t_set clutch_set(input gss_pkg::t_gear g);
        logic [gss_pkg::TABLE_W-1:0] shifted;
        if (g > gss_pkg::GEAR_REVERSE) begin
            return '0;
        end
        shifted = c_table >> (g * ELEMENTS);
        return shifted[ELEMENTS-1:0];
    endfunction

    function automatic gss_pkg::t_pct clip_pct(input logic [63:0] v);
        return (v > gss_pkg::PROG_MAX) ? gss_pkg::PROG_MAX : v[gss_pkg::PCT_W-1:0];
    endfunction

    function automatic void enter_phase(input gss_pkg::t_phase p, input logic [31:0] now);
        m_phase = p;
        m_start = now;
        if (p == gss_pkg::PH_IDLE) begin
            m_ack = 1'b0;
        end
    endfunction

    function automatic bit is_forward(input gss_pkg::t_gear g);
        return g >= gss_pkg::GEAR_FIRST && g <= gss_pkg::GEAR_TOP;
    endfunction

    // Advances the shadow sequencer by one tick and forms the result word it reports.
    function automatic t_shift_result advance_sequencer(input t_tick tk);
        t_shift_result r;
        gss_pkg::t_set cur_set;
        gss_pkg::t_set nxt_set;
        logic [31:0]   lapse;
        logic [63:0]   wide;
        if (tk.request) begin
            m_goal = tk.gear;
        end
        if (tk.ack) begin
            m_ack = 1'b1;
        end
        // An out-of-range goal aborts whatever is running and latches a fault.
        if (m_goal > gss_pkg::GEAR_REVERSE) begin
            m_fault = gss_pkg::FLT_INVALID;
            m_goal  = m_cur;
            enter_phase(gss_pkg::PH_IDLE, tk.now_ms);
        end
        lapse = tk.now_ms - m_start;
        case (m_phase)
            gss_pkg::PH_IDLE: begin
                if (m_cur != m_goal && m_fault == gss_pkg::FLT_NONE) begin
                    if (is_forward(m_cur) && is_forward(m_goal)) begin
                        m_step = (m_goal > m_cur) ? m_cur + 4'd1 : m_cur - 4'd1;
                    end else if (m_cur == gss_pkg::GEAR_NEUTRAL) begin
                        m_step = (m_goal == gss_pkg::GEAR_REVERSE) ? gss_pkg::GEAR_REVERSE
                                                                   : gss_pkg::GEAR_FIRST;
                    end else begin
                        m_step = gss_pkg::GEAR_NEUTRAL;
                    end
                    // Moves into or out of neutral skip the torque-cut handshake.
                    if (m_cur == gss_pkg::GEAR_NEUTRAL || m_step == gss_pkg::GEAR_NEUTRAL) begin
                        enter_phase(gss_pkg::PH_OVERLAP, tk.now_ms);
                    end else begin
                        enter_phase(gss_pkg::PH_PREFILL, tk.now_ms);
                    end
                end
            end
            gss_pkg::PH_PREFILL: begin
                if (lapse >= c_prefill) begin
                    enter_phase(gss_pkg::PH_CUT, tk.now_ms);
                end
            end
            gss_pkg::PH_CUT: begin
                if (m_ack) begin
                    enter_phase(gss_pkg::PH_OVERLAP, tk.now_ms);
                end else if (lapse >= c_ack_to) begin
                    m_fault = gss_pkg::FLT_TIMEOUT;
                    m_goal  = m_cur;
                    enter_phase(gss_pkg::PH_IDLE, tk.now_ms);
                end
            end
            gss_pkg::PH_OVERLAP: begin
                if (lapse >= c_overlap) begin
                    if (m_step != m_cur) begin
                        gear_changes++;
                    end
                    m_cur = m_step;
                    enter_phase(gss_pkg::PH_DONE, tk.now_ms);
                end
            end
            gss_pkg::PH_DONE: begin
                if (lapse >= c_restore) begin
                    enter_phase(gss_pkg::PH_IDLE, tk.now_ms);
                end
            end
            default: begin
            end
        endcase

        // The result reflects the state after this tick.
        cur_set       = clutch_set(m_cur);
        nxt_set       = clutch_set(m_step);
        lapse         = tk.now_ms - m_start;
        r             = '0;
        r.gear_now    = m_cur;
        r.gear_goal   = m_goal;
        r.phase       = m_phase;
        r.fault       = m_fault;
        r.active      = (m_phase != gss_pkg::PH_IDLE);
        r.engaged     = cur_set;
        r.progress    = gss_pkg::PROG_MAX;
        case (m_phase)
            gss_pkg::PH_PREFILL: begin
                r.ramp_in = nxt_set & ~cur_set;
                if (c_prefill == 0) begin
                    r.progress = '0;
                end else begin
                    wide       = lapse;
                    wide       = wide * c_pct;
                    wide       = wide / c_prefill;
                    r.progress = clip_pct(wide);
                end
            end
            gss_pkg::PH_CUT: begin
                r.ramp_in     = nxt_set & ~cur_set;
                r.progress    = clip_pct(c_pct);
                r.cut_request = 1'b1;
            end
            gss_pkg::PH_OVERLAP: begin
                r.engaged  = cur_set & nxt_set;
                r.ramp_in  = nxt_set & ~cur_set;
                r.ramp_out = cur_set & ~nxt_set;
                if (c_overlap != 0) begin
                    wide       = lapse;
                    wide       = wide * 100;
                    wide       = wide / c_overlap;
                    r.progress = clip_pct(wide);
                end
                r.cut_request = !(m_cur == gss_pkg::GEAR_NEUTRAL ||
                                  m_step == gss_pkg::GEAR_NEUTRAL);
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic string describe(input t_shift_result r);
        return $sformatf({"gear %0d goal %0d phase %0d fault %0d active %0d eng %b in %b ",
                          "out %b prog %0d cut %0d"},
                         r.gear_now, r.gear_goal, r.phase, r.fault, r.active, r.engaged,
                         r.ramp_in, r.ramp_out, r.progress, r.cut_request);
    endfunction

    // Tick driver: one word at a time from the pending queue, with random gaps.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            tick_bus.valid <= 1'b0;
        end else if (!tick_bus.valid || tick_taken) begin
            if (tick_gap > 0) begin
                tick_gap = tick_gap - 1;
                tick_bus.valid <= 1'b0;
            end else if (pending_ticks.size() != 0) begin
                tick_word = pending_ticks.pop_front();
                tick_bus.valid          <= 1'b1;
                tick_bus.now_ms         <= tick_word.now_ms;
                tick_bus.request_valid  <= tick_word.request;
                tick_bus.requested_gear <= tick_word.gear;
                tick_bus.torque_ack     <= tick_word.ack;
                tick_gap = draw_gap();
            end else begin
                tick_bus.valid <= 1'b0;
            end
        end
    end

    // Result back-pressure: random gaps after each word, plus one long hold on request.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            result_bus.ready <= 1'b0;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD - 1;
            result_bus.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            result_bus.ready <= 1'b0;
        end else if (ready_gap > 0) begin
            ready_gap = ready_gap - 1;
            result_bus.ready <= 1'b0;
        end else if (result_taken) begin
            gap_draw = draw_gap();
            if (gap_draw != 0) begin
                ready_gap = gap_draw - 1;
                result_bus.ready <= 1'b0;
            end else begin
                result_bus.ready <= 1'b1;
            end
        end else begin
            result_bus.ready <= 1'b1;
        end
    end

    // Monitor: checks each result word against the oldest expectation, then predicts
    // the result of any tick word taken on the same edge.
    always @(posedge i_clk) begin
        tick_taken   <= i_rst_n && tick_bus.valid && tick_bus.ready;
        result_taken <= i_rst_n && result_bus.valid && result_bus.ready;
        if (i_rst_n && result_bus.valid && result_bus.ready) begin
            got = {result_bus.gear_now, result_bus.gear_goal, result_bus.phase_code,
                   result_bus.fault_code, result_bus.in_shift, result_bus.held_set,
                   result_bus.ramp_in_set, result_bus.ramp_out_set, result_bus.ramp_pct,
                   result_bus.cut_req};
            results_checked++;
            if (expected_results.size() == 0) begin
                if (mismatch_count < 10) begin
                    $display("ERROR %0t: result word with nothing expected: %s",
                             $realtime, describe(got));
                end
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    if (mismatch_count < 10) begin
                        $display("ERROR %0t: result word %0d differs", $realtime,
                                 results_checked);
                        $display("  expected %s", describe(want));
                        $display("  actual   %s", describe(got));
                    end
                    mismatch_count++;
                end
            end
        end
        if (i_rst_n && tick_bus.valid && tick_bus.ready) begin
            expected_results.push_back(advance_sequencer({tick_bus.now_ms,
                tick_bus.request_valid, tick_bus.requested_gear, tick_bus.torque_ack}));
            ticks_taken <= ticks_taken + 1;
        end
    end

    // Watchdog on cycles in which no word moves on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (tick_bus.valid && tick_bus.ready) ||
            (result_bus.valid && result_bus.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("ERROR %0t: no word moved for %0d cycles", $realtime, idle_cycles);
            $display("Verification failed");
            $finish;
        end
    end

    // Queues one tick word and waits until the sequencer has taken it.
    task automatic step_tick(input logic [31:0] delta, input logic req,
                             input gss_pkg::t_gear g, input logic ack);
        clock_ms = clock_ms + delta;
        pending_ticks.push_back({clock_ms, req, g, ack});
        ticks_issued++;
        while (ticks_taken != ticks_issued) begin
            @(posedge i_clk);
        end
    endtask

    // Waits until every tick word is taken and every result word has come back.
    task automatic drain();
        while (ticks_taken != ticks_issued || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [gss_pkg::TABLE_W-1:0] val);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            gss_pkg::CFG_PREFILL_TIME: c_prefill = val[gss_pkg::MS_W-1:0];
            gss_pkg::CFG_ACK_TIMEOUT:  c_ack_to  = val[gss_pkg::MS_W-1:0];
            gss_pkg::CFG_OVERLAP_TIME: c_overlap = val[gss_pkg::MS_W-1:0];
            gss_pkg::CFG_RESTORE_TIME: c_restore = val[gss_pkg::MS_W-1:0];
            gss_pkg::CFG_PREFILL_PCT:  c_pct     = val[gss_pkg::PCT_W-1:0];
            gss_pkg::CFG_CLUTCH_TABLE: c_table   = val;
            default: begin
            end
        endcase
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_setting(input int unsigned prefill, input int unsigned ack_to,
                                 input int unsigned overlap, input int unsigned restore,
                                 input int unsigned pct,
                                 input logic [gss_pkg::TABLE_W-1:0] tbl);
        write_reg(gss_pkg::CFG_PREFILL_TIME, prefill);
        write_reg(gss_pkg::CFG_ACK_TIMEOUT, ack_to);
        write_reg(gss_pkg::CFG_OVERLAP_TIME, overlap);
        write_reg(gss_pkg::CFG_RESTORE_TIME, restore);
        write_reg(gss_pkg::CFG_PREFILL_PCT, pct);
        write_reg(gss_pkg::CFG_CLUTCH_TABLE, tbl);
        settings_applied++;
    endtask

    function automatic logic [gss_pkg::TABLE_W-1:0] random_table();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[gss_pkg::TABLE_W-1:0];
    endfunction

    // A phase duration at an extreme or small and random.
    function automatic int unsigned pick_duration();
        int unsigned r;
        r = $urandom_range(0, 2);
        if (r == 0) begin
            return 0;
        end
        if (r == 1) begin
            return 65535;
        end
        return $urandom_range(1, 40);
    endfunction

    // One random tick word. Time mostly creeps forward, sometimes jumps past the
    // longest phase, and rarely leaps anywhere in the 32-bit range.
    task automatic random_tick(input t_gen_mode mode);
        logic [31:0]    span;
        logic [31:0]    delta;
        logic [31:0]    lapse;
        int unsigned    r;
        logic           req;
        logic           ack;
        gss_pkg::t_gear g;
        span = c_prefill;
        if (c_overlap > span) begin
            span = c_overlap;
        end
        if (c_restore > span) begin
            span = c_restore;
        end
        span = span + 2;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            delta = $urandom_range(0, 2);
        end else if (r < 88) begin
            delta = $urandom_range(0, span);
        end else if (r < 98) begin
            delta = $urandom_range(span, 2 * span + 4);
        end else begin
            delta = $urandom();
        end
        case (mode)
            GEN_SAFE: begin
                req   = ($urandom_range(0, 5) == 0);
                g     = $urandom_range(gss_pkg::GEAR_NEUTRAL, gss_pkg::GEAR_REVERSE);
                ack   = ($urandom_range(0, 3) == 0);
                lapse = clock_ms + delta - m_start;
                // A timeout fault is permanent, so acknowledge before it would fire.
                if (m_phase == gss_pkg::PH_CUT && !m_ack && lapse >= c_ack_to) begin
                    ack = 1'b1;
                end
            end
            GEN_STARVE: begin
                req = ($urandom_range(0, 3) == 0);
                g   = $urandom_range(gss_pkg::GEAR_FIRST, gss_pkg::GEAR_TOP);
                ack = 1'b0;
            end
            default: begin
                req = $urandom_range(0, 1);
                g   = $urandom_range(0, 15);
                ack = $urandom_range(0, 1);
            end
        endcase
        step_tick(delta, req, g, ack);
    endtask

    initial begin : stimulus
        int unsigned sel;
        int unsigned n;
        bit          timeout_path;

        // Known values on every input from time zero.
        i_rst_n                 = 1'b0;
        cfg_we                  = 1'b0;
        cfg_idx                 = gss_pkg::CFG_PREFILL_TIME;
        cfg_data                = '0;
        tick_bus.valid          = 1'b0;
        tick_bus.now_ms         = '0;
        tick_bus.request_valid  = 1'b0;
        tick_bus.requested_gear = gss_pkg::GEAR_NEUTRAL;
        tick_bus.torque_ack     = 1'b0;
        result_bus.ready        = 1'b0;

        m_cur   = gss_pkg::GEAR_NEUTRAL;
        m_goal  = gss_pkg::GEAR_NEUTRAL;
        m_step  = gss_pkg::GEAR_NEUTRAL;
        m_phase = gss_pkg::PH_IDLE;
        m_fault = gss_pkg::FLT_NONE;
        m_start = '0;
        m_ack   = 1'b0;
        c_prefill = '0;
        c_ack_to  = '0;
        c_overlap = '0;
        c_restore = '0;
        c_pct     = '0;
        c_table   = '0;

        ticks_issued     = 0;
        ticks_taken      = 0;
        results_checked  = 0;
        mismatch_count   = 0;
        gear_changes     = 0;
        settings_applied = 0;
        idle_cycles      = 0;
        tick_gap         = 0;
        ready_gap        = 0;
        hold_left        = 0;
        hold_request     = 1'b0;
        calm_mode        = 1'b0;
        tick_taken       = 1'b0;
        result_taken     = 1'b0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed walk: stale acknowledge, start from neutral, a forward step with
        // partial ramps, a goal change in mid-shift, reverse through neutral and
        // back, with the time stamp wrapping on the way.
        apply_setting(2, 4, 2, 1, 60, random_table());
        clock_ms = 32'hFFFF_FFF0;
        step_tick(0, 1'b0, gss_pkg::GEAR_NEUTRAL, 1'b1);
        step_tick(3, 1'b1, gss_pkg::GEAR_TOP, 1'b0);
        step_tick(3, 1'b0, gss_pkg::GEAR_NEUTRAL, 1'b0);
        step_tick(3, 1'b0, gss_pkg::GEAR_NEUTRAL, 1'b0);
        step_tick(3, 1'b0, gss_pkg::GEAR_NEUTRAL, 1'b1);
        step_tick(1, 1'b0, gss_pkg::GEAR_NEUTRAL, 1'b0);
        step_tick(2, 1'b0, gss_pkg::GEAR_NEUTRAL, 1'b0);
        step_tick(1, 1'b0, gss_pkg::GEAR_NEUTRAL, 1'b0);
        step_tick(1, 1'b0, gss_pkg::GEAR_NEUTRAL, 1'b0);
        step_tick(3, 1'b1, gss_pkg::GEAR_REVERSE, 1'b0);
        step_tick(0, 1'b0, gss_pkg::GEAR_NEUTRAL, 1'b0);
        step_tick(3, 1'b0, gss_pkg::GEAR_NEUTRAL, 1'b0);
        step_tick(3, 1'b0, gss_pkg::GEAR_NEUTRAL, 1'b0);
        step_tick(3, 1'b0, gss_pkg::GEAR_NEUTRAL, 1'b0);
        step_tick(3, 1'b0, gss_pkg::GEAR_NEUTRAL, 1'b0);
        step_tick(3, 1'b0, gss_pkg::GEAR_NEUTRAL, 1'b0);
        step_tick(3, 1'b0, gss_pkg::GEAR_NEUTRAL, 1'b0);
        step_tick(3, 1'b0, gss_pkg::GEAR_NEUTRAL, 1'b0);
        step_tick(3, 1'b1, gss_pkg::GEAR_FIRST, 1'b0);
        step_tick(3, 1'b0, gss_pkg::GEAR_NEUTRAL, 1'b0);
        drain();

        // Random shifting under a range of settings, with no fault allowed to occur.
        for (sel = 0; sel < 6; sel++) begin
            case (sel)
                0: apply_setting(3, 5, 4, 2, 60, random_table());
                1: apply_setting(0, 0, 0, 0, 0, '0);
                2: apply_setting(65535, 65535, 65535, 65535, 100, '1);
                3: apply_setting($urandom_range(0, 8), $urandom_range(0, 8),
                                 $urandom_range(0, 8), $urandom_range(0, 8),
                                 $urandom_range(0, 100), random_table());
                4: apply_setting(pick_duration(), pick_duration(), pick_duration(),
                                 pick_duration(), $urandom_range(0, 100), random_table());
                default: apply_setting($urandom_range(1, 12), $urandom_range(0, 12),
                                       $urandom_range(1, 12), $urandom_range(0, 12),
                                       100, random_table());
            endcase
            calm_mode = (sel == 1 || sel == 4);
            for (n = 0; n < PHASE_TICKS; n++) begin
                if (sel == 0 && n == 20) begin
                    hold_request = 1'b1;
                end
                random_tick(GEN_SAFE);
            end
            drain();
        end

        // The fault latches until reset, so only one way into it can be taken per run:
        // either a torque-cut timeout or an invalid target in mid-shift.
        apply_setting(1, 2, 1, 0, $urandom_range(0, 100), random_table());
        calm_mode    = 1'b0;
        timeout_path = $urandom_range(0, 1);
        if (timeout_path) begin
            for (n = 0; n < 150 && m_fault == gss_pkg::FLT_NONE; n++) begin
                random_tick(GEN_STARVE);
            end
        end else begin
            for (n = 0; n < 80 && m_phase == gss_pkg::PH_IDLE; n++) begin
                random_tick(GEN_SAFE);
            end
            step_tick(1, 1'b1, $urandom_range(gss_pkg::GEAR_REVERSE + 1, 15), 1'b0);
        end
        for (n = 0; n < 40; n++) begin
            random_tick(GEN_FREE);
        end

        drain();
        repeat (60) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $display("ERROR: %0d result words never arrived", expected_results.size());
            mismatch_count = mismatch_count + expected_results.size();
        end

        $display("Summary: %0d tick words checked over %0d register settings, %0d gear changes.",
                 results_checked, settings_applied, gear_changes);
        $display("Summary: fault path taken was %s, final fault code %0d.",
                 timeout_path ? "torque-cut timeout" : "invalid target in mid-shift", m_fault);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
